// File: rtl/hmth_pkg.sv
package hmth_pkg;

   // grid geometry
   localparam int GRID_SIDE_MAX = 129;
   localparam int STORE_DEPTH   = GRID_SIDE_MAX * GRID_SIDE_MAX;
   localparam int ADDR_W        = 15;
   localparam int SIDE_W        = 8;
   localparam int HGT_W         = 16;
   localparam int POS_W         = 24;
   localparam int CELL_W        = 16;
   localparam int DBL_W         = CELL_W + 1;

   // shifted position (1/512 units), cell index, offsets
   localparam int U_W      = POS_W + 2;
   localparam int XR_W     = U_W - 1;
   localparam int CELL_Q_W = $clog2(GRID_SIDE_MAX - 1);
   localparam int R_W      = U_W + 1;

   // interpolation numerator and final divider
   localparam int SCL_W  = 32;
   localparam int DIF_W  = SCL_W + 1;
   localparam int SPL_W  = 14;
   localparam int N_W    = 62;
   localparam int QUOT_W = 40;
   localparam int NB_W   = DBL_W + QUOT_W;
   localparam int OUT_W  = 32;
   localparam int FRAC_SHIFT = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CSR_NUM_COLS     = 2'd0,
      CSR_NUM_ROWS     = 2'd1,
      CSR_CELL_SIZE    = 2'd2,
      CSR_HEIGHT_SCALE = 2'd3
   } hmth_csr_type;

   // clamped configuration
   typedef struct packed {
      logic [SIDE_W-1:0] cols;
      logic [SIDE_W-1:0] rows;
      logic [CELL_W-1:0] spacing;
      logic [CELL_W-1:0] scale;
   } hmth_cfg_type;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] addr;
      logic [HGT_W-1:0]  value;
      logic [U_W-1:0]    ux;
      logic [U_W-1:0]    uz;
   } hmth_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hmth_queue_status_type;

endpackage

// File: rtl/hmth_front.sv
module hmth_front import hmth_pkg::*; (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [ADDR_W-1:0]        req_height_addr,
   input  logic signed [HGT_W-1:0]  req_height_value,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  hmth_cfg_type             cfg,
   input  hmth_queue_status_type    q_status,
   output logic                     push,
   output hmth_item_type            push_item
);

   logic [POS_W-1:0] ext_x;
   logic [POS_W-1:0] ext_z;

   // half grid extent, in 1/512 units: (n-1)*cell
   assign ext_x = POS_W'(cfg.cols - SIDE_W'(1)) * POS_W'(cfg.spacing);
   assign ext_z = POS_W'(cfg.rows - SIDE_W'(1)) * POS_W'(cfg.spacing);

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_item.op    = req_op;
      push_item.addr  = req_height_addr;
      push_item.value = req_height_value;
      push_item.ux    = {2'b00, ext_x} + {req_pos_x[POS_W-1], req_pos_x, 1'b0};
      push_item.uz    = {2'b00, ext_z} - {req_pos_z[POS_W-1], req_pos_z, 1'b0};
   end

endmodule

// File: rtl/hmth_queue.sv
module hmth_queue import hmth_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hmth_item_type         push_item,
   input  logic                  pop,
   output hmth_item_type         head_item,
   output hmth_queue_status_type status
);

   hmth_item_type          slot_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: rtl/hmth_back.sv
module hmth_back import hmth_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  hmth_cfg_type          cfg,
   input  logic                  in_valid,
   input  hmth_item_type         in_item,
   output logic                  out_valid,
   output logic signed [N_W-1:0] out_num
);

   logic [DBL_W-1:0] dbl;
   assign dbl = {cfg.spacing, 1'b0};

   // ---- cell divider: one quotient bit per stage ----
   logic                cv_ff   [0:CELL_Q_W];
   hmth_item_type       ci_ff   [0:CELL_Q_W];
   logic [XR_W-1:0]     xr_ff   [0:CELL_Q_W];
   logic [XR_W-1:0]     zr_ff   [0:CELL_Q_W];
   logic [CELL_Q_W-1:0] xq_ff   [0:CELL_Q_W];
   logic [CELL_Q_W-1:0] zq_ff   [0:CELL_Q_W];
   logic                xneg_ff [0:CELL_Q_W];
   logic                zneg_ff [0:CELL_Q_W];
   logic                xsat_ff [0:CELL_Q_W];
   logic                zsat_ff [0:CELL_Q_W];

   logic [XR_W-1:0]     xr_in [1:CELL_Q_W];
   logic [XR_W-1:0]     zr_in [1:CELL_Q_W];
   logic [CELL_Q_W-1:0] xq_in [1:CELL_Q_W];
   logic [CELL_Q_W-1:0] zq_in [1:CELL_Q_W];
   logic [XR_W-1:0]     lim0;

   assign lim0 = {1'b0, dbl, {CELL_Q_W{1'b0}}};

   always_comb begin
      for (int k = 0; k < CELL_Q_W; k++) begin
         xr_in[k+1] = xr_ff[k];
         zr_in[k+1] = zr_ff[k];
         xq_in[k+1] = xq_ff[k];
         zq_in[k+1] = zq_ff[k];
         if (xr_ff[k] >= (XR_W'(dbl) << (CELL_Q_W-1-k))) begin
            xr_in[k+1] = xr_ff[k] - (XR_W'(dbl) << (CELL_Q_W-1-k));
            xq_in[k+1][CELL_Q_W-1-k] = 1'b1;
         end
         if (zr_ff[k] >= (XR_W'(dbl) << (CELL_Q_W-1-k))) begin
            zr_in[k+1] = zr_ff[k] - (XR_W'(dbl) << (CELL_Q_W-1-k));
            zq_in[k+1][CELL_Q_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CELL_Q_W; k++) begin
            cv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         cv_ff[0] <= in_valid;
         for (int k = 0; k < CELL_Q_W; k++) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ci_ff[0]   <= in_item;
         xr_ff[0]   <= in_item.ux[XR_W-1:0];
         zr_ff[0]   <= in_item.uz[XR_W-1:0];
         xq_ff[0]   <= '0;
         zq_ff[0]   <= '0;
         xneg_ff[0] <= in_item.ux[U_W-1];
         zneg_ff[0] <= in_item.uz[U_W-1];
         xsat_ff[0] <= in_item.ux[XR_W-1:0] >= lim0;
         zsat_ff[0] <= in_item.uz[XR_W-1:0] >= lim0;
         for (int k = 0; k < CELL_Q_W; k++) begin
            ci_ff[k+1]   <= ci_ff[k];
            xr_ff[k+1]   <= xr_in[k+1];
            zr_ff[k+1]   <= zr_in[k+1];
            xq_ff[k+1]   <= xq_in[k+1];
            zq_ff[k+1]   <= zq_in[k+1];
            xneg_ff[k+1] <= xneg_ff[k];
            zneg_ff[k+1] <= zneg_ff[k];
            xsat_ff[k+1] <= xsat_ff[k];
            zsat_ff[k+1] <= zsat_ff[k];
         end
      end
   end

   // ---- clamp into grid ----
   logic [CELL_Q_W-1:0] col_lim, row_lim, qc, qr;
   logic [CELL_Q_W-1:0] col_in, row_in, col_ff, row_ff;
   logic                c1v_ff;
   hmth_item_type       c1i_ff;

   always_comb begin
      col_lim = CELL_Q_W'(cfg.cols - SIDE_W'(2));
      row_lim = CELL_Q_W'(cfg.rows - SIDE_W'(2));
      qc = xneg_ff[CELL_Q_W] ? '0 : (xsat_ff[CELL_Q_W] ? '1 : xq_ff[CELL_Q_W]);
      qr = zneg_ff[CELL_Q_W] ? '0 : (zsat_ff[CELL_Q_W] ? '1 : zq_ff[CELL_Q_W]);
      col_in = (qc > col_lim) ? col_lim : qc;
      row_in = (qr > row_lim) ? row_lim : qr;
   end

   // ---- offsets and base index ----
   logic                c2v_ff;
   hmth_item_type       c2i_ff;
   logic [R_W-1:0]      rx_ff, rz_ff, rx_in, rz_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [POS_W-1:0]    colmul, rowmul;

   always_comb begin
      colmul = POS_W'(col_ff) * POS_W'(dbl);
      rowmul = POS_W'(row_ff) * POS_W'(dbl);
      rx_in  = {c1i_ff.ux[U_W-1], c1i_ff.ux} - {3'b000, colmul};
      rz_in  = {c1i_ff.uz[U_W-1], c1i_ff.uz} - {3'b000, rowmul};
      idx_in = ADDR_W'(row_ff) * ADDR_W'(cfg.cols) + ADDR_W'(col_ff);
   end

   // ---- triangle pick and corner addresses ----
   logic                c3v_ff;
   hmth_item_type       c3i_ff;
   logic [R_W:0]        rsum;
   logic                lower_in, lower_ff;
   logic [R_W-1:0]      s_in, t_in, s_ff, t_ff;
   logic [ADDR_W-1:0]   ad_a_ff, ad_b_ff, ad_c_ff, ad_d_ff;

   always_comb begin
      rsum     = {rx_ff[R_W-1], rx_ff} + {rz_ff[R_W-1], rz_ff};
      lower_in = $signed(rsum) >= $signed({{(R_W+1-DBL_W){1'b0}}, dbl});
      s_in     = lower_in ? (R_W'(dbl) - rx_ff) : rx_ff;
      t_in     = lower_in ? (R_W'(dbl) - rz_ff) : rz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1v_ff <= 1'b0;
         c2v_ff <= 1'b0;
         c3v_ff <= 1'b0;
      end else if (adv) begin
         c1v_ff <= cv_ff[CELL_Q_W];
         c2v_ff <= c1v_ff;
         c3v_ff <= c2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1i_ff   <= ci_ff[CELL_Q_W];
         col_ff   <= col_in;
         row_ff   <= row_in;
         c2i_ff   <= c1i_ff;
         rx_ff    <= rx_in;
         rz_ff    <= rz_in;
         idx_ff   <= idx_in;
         c3i_ff   <= c2i_ff;
         lower_ff <= lower_in;
         s_ff     <= s_in;
         t_ff     <= t_in;
         ad_a_ff  <= idx_ff;
         ad_b_ff  <= idx_ff + ADDR_W'(1);
         ad_c_ff  <= idx_ff + ADDR_W'(cfg.cols);
         ad_d_ff  <= idx_ff + ADDR_W'(cfg.cols) + ADDR_W'(1);
      end
   end

   // ---- height store: two copies, two read ports each ----
   logic [HGT_W-1:0] mem_top [0:STORE_DEPTH-1];
   logic [HGT_W-1:0] mem_bot [0:STORE_DEPTH-1];
   logic [HGT_W-1:0] rd_a_ff, rd_b_ff, rd_c_ff, rd_d_ff;
   logic             wr_en;
   logic             mv_ff;
   logic             m_lower_ff;
   logic [R_W-1:0]   m_s_ff, m_t_ff;

   assign wr_en = adv && c3v_ff && (c3i_ff.op == OP_WRITE)
                  && (c3i_ff.addr < ADDR_W'(STORE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_top[c3i_ff.addr] <= c3i_ff.value;
         mem_bot[c3i_ff.addr] <= c3i_ff.value;
      end
      if (adv) begin
         rd_a_ff <= mem_top[ad_a_ff];
         rd_b_ff <= mem_top[ad_b_ff];
         rd_c_ff <= mem_bot[ad_c_ff];
         rd_d_ff <= mem_bot[ad_d_ff];
      end
   end

   // ---- scale, select, multiply, sum ----
   logic signed [SCL_W:0]     pa, pb, pc, pd;
   logic signed [SCL_W-1:0]   ha_ff, hb_ff, hc_ff, hd_ff;
   logic                      hv_ff, h_lower_ff;
   logic [R_W-1:0]            h_s_ff, h_t_ff;
   logic signed [SCL_W-1:0]   p_ff;
   logic signed [DIF_W-1:0]   e_ff, f_ff;
   logic                      ev_ff;
   logic [R_W-1:0]            e_s_ff, e_t_ff;
   logic signed [DIF_W+SPL_W:0]       pe_lo, pf_lo, pe_lo_ff, pf_lo_ff;
   logic signed [DIF_W+R_W-SPL_W-1:0] pe_hi, pf_hi, pe_hi_ff, pf_hi_ff;
   logic signed [SCL_W+DBL_W:0]       pp, pp_ff, pp1_ff;
   logic                      xv_ff, y1v_ff, y2v_ff;
   logic signed [N_W-1:0]     se_ff, sf_ff, n_ff;

   always_comb begin
      pa = $signed(rd_a_ff) * $signed({1'b0, cfg.scale});
      pb = $signed(rd_b_ff) * $signed({1'b0, cfg.scale});
      pc = $signed(rd_c_ff) * $signed({1'b0, cfg.scale});
      pd = $signed(rd_d_ff) * $signed({1'b0, cfg.scale});
      pe_lo = e_ff * $signed({1'b0, e_s_ff[SPL_W-1:0]});
      pf_lo = f_ff * $signed({1'b0, e_t_ff[SPL_W-1:0]});
      pe_hi = e_ff * $signed(e_s_ff[R_W-1:SPL_W]);
      pf_hi = f_ff * $signed(e_t_ff[R_W-1:SPL_W]);
      pp    = p_ff * $signed({1'b0, dbl});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff  <= 1'b0;
         hv_ff  <= 1'b0;
         ev_ff  <= 1'b0;
         xv_ff  <= 1'b0;
         y1v_ff <= 1'b0;
         y2v_ff <= 1'b0;
      end else if (adv) begin
         mv_ff  <= c3v_ff && (c3i_ff.op == OP_QUERY);
         hv_ff  <= mv_ff;
         ev_ff  <= hv_ff;
         xv_ff  <= ev_ff;
         y1v_ff <= xv_ff;
         y2v_ff <= y1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_lower_ff <= lower_ff;
         m_s_ff     <= s_ff;
         m_t_ff     <= t_ff;
         ha_ff      <= pa[SCL_W-1:0];
         hb_ff      <= pb[SCL_W-1:0];
         hc_ff      <= pc[SCL_W-1:0];
         hd_ff      <= pd[SCL_W-1:0];
         h_lower_ff <= m_lower_ff;
         h_s_ff     <= m_s_ff;
         h_t_ff     <= m_t_ff;
         // lower triangle pivots on D, upper on A
         if (h_lower_ff) begin
            p_ff <= hd_ff;
            e_ff <= DIF_W'(hc_ff) - DIF_W'(hd_ff);
            f_ff <= DIF_W'(hb_ff) - DIF_W'(hd_ff);
         end else begin
            p_ff <= ha_ff;
            e_ff <= DIF_W'(hb_ff) - DIF_W'(ha_ff);
            f_ff <= DIF_W'(hc_ff) - DIF_W'(ha_ff);
         end
         e_s_ff   <= h_s_ff;
         e_t_ff   <= h_t_ff;
         pe_lo_ff <= pe_lo;
         pf_lo_ff <= pf_lo;
         pe_hi_ff <= pe_hi;
         pf_hi_ff <= pf_hi;
         pp_ff    <= pp;
         se_ff    <= (N_W'(pe_hi_ff) <<< SPL_W) + N_W'(pe_lo_ff);
         sf_ff    <= (N_W'(pf_hi_ff) <<< SPL_W) + N_W'(pf_lo_ff);
         pp1_ff   <= pp_ff;
         n_ff     <= N_W'(pp1_ff) + se_ff + sf_ff;
      end
   end

   assign out_valid = y2v_ff;
   assign out_num   = n_ff;

endmodule

// File: rtl/hmth_div.sv
module hmth_div import hmth_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  hmth_cfg_type          cfg,
   input  logic                  in_valid,
   input  logic signed [N_W-1:0] in_num,
   output logic                  out_valid,
   output logic [OUT_W-1:0]      out_height
);

   logic [DBL_W-1:0]      dbl;
   logic signed [N_W-1:0] lim;
   logic [N_W-1:0]        biased;

   assign dbl    = {cfg.spacing, 1'b0};
   assign lim    = $signed(N_W'({dbl, {(QUOT_W-1){1'b0}}}));
   assign biased = in_num + lim;

   logic              v_ff   [0:QUOT_W];
   logic              shi_ff [0:QUOT_W];
   logic              slo_ff [0:QUOT_W];
   logic [NB_W-1:0]   rem_ff [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff   [0:QUOT_W];
   logic [NB_W-1:0]   rem_in [1:QUOT_W];
   logic [QUOT_W-1:0] q_in   [1:QUOT_W];

   always_comb begin
      for (int k = 0; k < QUOT_W; k++) begin
         rem_in[k+1] = rem_ff[k];
         q_in[k+1]   = q_ff[k];
         if (rem_ff[k] >= (NB_W'(dbl) << (QUOT_W-1-k))) begin
            rem_in[k+1] = rem_ff[k] - (NB_W'(dbl) << (QUOT_W-1-k));
            q_in[k+1][QUOT_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUOT_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < QUOT_W; k++) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         shi_ff[0] <= in_num >= lim;
         slo_ff[0] <= in_num < -lim;
         rem_ff[0] <= biased[NB_W-1:0];
         q_ff[0]   <= '0;
         for (int k = 0; k < QUOT_W; k++) begin
            shi_ff[k+1] <= shi_ff[k];
            slo_ff[k+1] <= slo_ff[k];
            rem_ff[k+1] <= rem_in[k+1];
            q_ff[k+1]   <= q_in[k+1];
         end
      end
   end

   // quotient carries a bias of 2^(QUOT_W-1); removing it flips the top bit
   always_comb begin
      priority if (shi_ff[QUOT_W]) begin
         out_height = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (slo_ff[QUOT_W]) begin
         out_height = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         out_height = {~q_ff[QUOT_W][QUOT_W-1], q_ff[QUOT_W][QUOT_W-2:FRAC_SHIFT]};
      end
   end

   assign out_valid = v_ff[QUOT_W];

endmodule

// File: rtl/heightmap_triangle_height_query.sv
// Heightmap triangle height query.
//
// Input channel (req_*): one word per cycle while req_stall is low. op = write
// stores height_value at height_addr (row * num_cols + col); op = query
// samples the terrain at (pos_x, pos_z) and returns one rsp word with the
// interpolated height. Writes return nothing. Words stay in order through the
// whole pipe, so a query sees every write accepted before it.
// Throughput: one word per cycle while rsp is not stalled. A query passes the
// cell divider (one quotient bit per stage), the clamp, triangle, store and
// multiply stages, then the final floor divider by 2*cell_size.
// A 4-word queue decouples the front from the back pipe; when rsp_stall
// holds a pending result the back pipe freezes, the queue fills and req_stall
// rises once it holds 4 words.
// Reset clears all valid state and loads num_cols/num_rows 129, cell_size and
// height_scale 256. The height store is not cleared: read only written
// entries. csr_* writes must be done while the block is idle.
module heightmap_triangle_height_query import hmth_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [ADDR_W-1:0]        req_height_addr,
   input  logic signed [HGT_W-1:0]  req_height_value,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_height,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [CELL_W-1:0]        csr_wr_data
);

   // config registers
   logic [SIDE_W-1:0] num_cols_ff, num_rows_ff;
   logic [CELL_W-1:0] cell_size_ff, height_scale_ff;
   hmth_cfg_type      cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff     <= SIDE_W'(GRID_SIDE_MAX);
         num_rows_ff     <= SIDE_W'(GRID_SIDE_MAX);
         cell_size_ff    <= CELL_W'(256);
         height_scale_ff <= CELL_W'(256);
      end else if (csr_wr_en) begin
         unique case (hmth_csr_type'(csr_index))
            CSR_NUM_COLS:     num_cols_ff     <= csr_wr_data[SIDE_W-1:0];
            CSR_NUM_ROWS:     num_rows_ff     <= csr_wr_data[SIDE_W-1:0];
            CSR_CELL_SIZE:    cell_size_ff    <= csr_wr_data;
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_wr_data;
         endcase
      end
   end

   // grid counts clamped to [2, max], zero cell size read as 1
   always_comb begin
      cfg.cols = (num_cols_ff < SIDE_W'(2)) ? SIDE_W'(2) :
                 (num_cols_ff > SIDE_W'(GRID_SIDE_MAX)) ? SIDE_W'(GRID_SIDE_MAX) :
                 num_cols_ff;
      cfg.rows = (num_rows_ff < SIDE_W'(2)) ? SIDE_W'(2) :
                 (num_rows_ff > SIDE_W'(GRID_SIDE_MAX)) ? SIDE_W'(GRID_SIDE_MAX) :
                 num_rows_ff;
      cfg.spacing = (cell_size_ff == '0) ? CELL_W'(1) : cell_size_ff;
      cfg.scale   = height_scale_ff;
   end

   // whole back pipe moves unless a result waits on a stalled receiver
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_height_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);

   hmth_queue_status_type q_status;
   hmth_item_type         push_item, head_item;
   logic                  push, pop;

   assign pop = adv && !q_status.empty;

   hmth_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_height_addr  (req_height_addr),
      .req_height_value (req_height_value),
      .req_pos_x        (req_pos_x),
      .req_pos_z        (req_pos_z),
      .cfg              (cfg),
      .q_status         (q_status),
      .push             (push),
      .push_item        (push_item)
   );

   hmth_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   logic                  num_valid;
   logic signed [N_W-1:0] num;

   hmth_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (!q_status.empty),
      .in_item   (head_item),
      .out_valid (num_valid),
      .out_num   (num)
   );

   logic             div_valid;
   logic [OUT_W-1:0] div_height;

   hmth_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg),
      .in_valid   (num_valid),
      .in_num     (num),
      .out_valid  (div_valid),
      .out_height (div_height)
   );

   // output register
   assign rsp_valid_in = adv ? div_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_height_ff <= div_height;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = $signed(rsp_height_ff);

   // a full queue with the back pipe frozen cannot drain
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !adv) |=> req_stall)
      else $error("queue drained while back pipe frozen");

   // a pop leaves room: no push can refill a full queue in the same cycle
   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      (adv && !q_status.empty) |=> !q_status.full)
      else $error("queue full right after a pop");

endmodule

// File: dv/tb_heightmap_triangle_height_query.sv
module tb_heightmap_triangle_height_query;
   import hmth_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT = 600000;
   localparam int  DRAIN_WAIT  = 80;   // time for a query to clear the pipe, plus the 4-word queue

   typedef struct {
      logic                    op;
      logic [ADDR_W-1:0]       addr;
      logic signed [HGT_W-1:0] value;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] pz;
      bit                      drain;   // hold this word until every height is back
   } hq_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_op = OP_WRITE;
   logic [ADDR_W-1:0]        req_height_addr = '0;
   logic signed [HGT_W-1:0]  req_height_value = '0;
   logic signed [POS_W-1:0]  req_pos_x = '0;
   logic signed [POS_W-1:0]  req_pos_z = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]  rsp_height;
   logic                     csr_wr_en = 1'b0;
   logic [1:0]               csr_index = CSR_NUM_COLS;
   logic [CELL_W-1:0]        csr_wr_data = '0;

   heightmap_triangle_height_query DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_op, .req_height_addr, .req_height_value,
      .req_pos_x, .req_pos_z,
      .rsp_valid, .rsp_stall, .rsp_height,
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the block: registers and height grid
   int unsigned            grid_cols = 129, grid_rows = 129, cell_q8 = 256, gain_q8 = 256;
   logic signed [HGT_W-1:0] grid_heights [0:STORE_DEPTH-1];

   hq_word_type         pending_words[$];
   logic signed [31:0]  expected_heights[$];
   int                  errors = 0;
   int                  cycles = 0;

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint scaled_vertex(longint row, longint col, longint cols);
      return longint'(grid_heights[row * cols + col]) * longint'(gain_q8);
   endfunction

   // interpolated terrain height, signed 32-bit integer (Q32.0), saturated
   function automatic logic signed [31:0] terrain_height(logic signed [POS_W-1:0] px,
                                                         logic signed [POS_W-1:0] pz);
      longint cols, rows, cs, dbl, ux, uz, col, row, rx, rz, a, b, c, d, num;
      cols = clampl(grid_cols, 2, GRID_SIDE_MAX);
      rows = clampl(grid_rows, 2, GRID_SIDE_MAX);
      cs   = (cell_q8 == 0) ? 1 : cell_q8;
      dbl  = 2 * cs;
      ux   = (cols - 1) * cs + 2 * longint'(px);
      uz   = (rows - 1) * cs - 2 * longint'(pz);
      col  = clampl(floor_quot(ux, dbl), 0, cols - 2);
      row  = clampl(floor_quot(uz, dbl), 0, rows - 2);
      rx   = ux - col * dbl;
      rz   = uz - row * dbl;
      a = scaled_vertex(row, col, cols);
      b = scaled_vertex(row, col + 1, cols);
      c = scaled_vertex(row + 1, col, cols);
      d = scaled_vertex(row + 1, col + 1, cols);
      if (rx + rz < dbl)
         num = a * dbl + (b - a) * rx + (c - a) * rz;   // upper triangle
      else
         num = d * dbl + (c - d) * (dbl - rx) + (b - d) * (dbl - rz);
      return 32'(clampl(floor_quot(num, dbl * 256), -64'sd2147483648, 64'sd2147483647));
   endfunction

   // ---------------------------------------------------------------- driver
   // bursts of random length, random gaps between them
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // stalled word holds
      end else begin
         if (req_valid) begin
            // word accepted: update the shadow grid or predict the height
            if (pending_words[0].op == OP_WRITE) begin
               if (pending_words[0].addr < STORE_DEPTH)
                  grid_heights[pending_words[0].addr] = pending_words[0].value;
            end else begin
               expected_heights.push_back(terrain_height(pending_words[0].px,
                                                         pending_words[0].pz));
            end
            void'(pending_words.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 &&
                      !(pending_words[0].drain && (expected_heights.size() > 0 || req_valid))) begin
            req_valid        <= 1'b1;
            req_op           <= pending_words[0].op;
            req_height_addr  <= pending_words[0].addr;
            req_height_value <= pending_words[0].value;
            req_pos_x        <= pending_words[0].px;
            req_pos_z        <= pending_words[0].pz;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------- monitor / check
   // receiver stall: modes switch between no stall, light and heavy stalling
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_heights.size() == 0) begin
               $error("unexpected height word: %0d", rsp_height);
               errors++;
            end else begin
               if (rsp_height !== expected_heights[0]) begin
                  $error("height: expected %0d, actual %0d", expected_heights[0], rsp_height);
                  errors++;
               end
               void'(expected_heights.pop_front());
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("[heightmap_triangle_height_query] ERROR");
         $finish;
      end
   end

   // --------------------------------------------------------------- stimulus
   function automatic void push_write(int unsigned addr, int value);
      hq_word_type w;
      w = '{op: OP_WRITE, addr: ADDR_W'(addr), value: HGT_W'(value), px: '0, pz: '0,
            drain: 1'b0};
      pending_words.push_back(w);
   endfunction

   function automatic void push_query(longint px, longint pz, bit drain = 1'b0);
      hq_word_type w;
      w = '{op: OP_QUERY, addr: ADDR_W'($urandom), value: HGT_W'($urandom),
            px: POS_W'(px), pz: POS_W'(pz), drain: drain};
      pending_words.push_back(w);
   endfunction

   function automatic int rand_height();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_heights.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(hmth_csr_type idx, int unsigned data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CELL_W'(data);
      case (idx)
         CSR_NUM_COLS:  grid_cols = data & 8'hFF;
         CSR_NUM_ROWS:  grid_rows = data & 8'hFF;
         CSR_CELL_SIZE: cell_q8   = data & 16'hFFFF;
         default:       gain_q8   = data & 16'hFFFF;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // configure, fill every vertex the grid can read, then mixed traffic
   task automatic run_phase(int unsigned c, int unsigned r, int unsigned cs,
                            int unsigned gain, int n_words);
      longint cols, rows, cse, ext_x, ext_z, px, pz;
      int unsigned span;
      wait_idle();
      csr_write(CSR_NUM_COLS, c);
      csr_write(CSR_NUM_ROWS, r);
      csr_write(CSR_CELL_SIZE, cs);
      csr_write(CSR_HEIGHT_SCALE, gain);
      cols  = clampl(c & 8'hFF, 2, GRID_SIDE_MAX);
      rows  = clampl(r & 8'hFF, 2, GRID_SIDE_MAX);
      cse   = (cs == 0) ? 1 : cs;
      span  = cols * rows;
      ext_x = (cols - 1) * cse;
      ext_z = (rows - 1) * cse;
      for (int i = 0; i < span; i++) push_write(i, rand_height());
      for (int i = 0; i < n_words; i++) begin
         case ($urandom_range(0, 19))
            0, 1: push_write($urandom_range(0, span - 1), rand_height());
            2:    push_write($urandom_range(0, 32767), rand_height());
            3, 4: push_query(longint'($urandom_range(0, 32'hFFFFFF)) - 8388608,
                             longint'($urandom_range(0, 32'hFFFFFF)) - 8388608);
            5, 6: // exact vertices
               push_query(longint'($urandom_range(0, cols - 1)) * cse - ext_x / 2,
                          ext_z / 2 - longint'($urandom_range(0, rows - 1)) * cse);
            default: begin
               px = longint'($urandom_range(0, ext_x + 2 * cse)) - ext_x / 2 - cse;
               pz = longint'($urandom_range(0, ext_z + 2 * cse)) - ext_z / 2 - cse;
               push_query(px, pz, i == n_words / 2);
            end
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: 4x3 grid, unit cells
      run_phase(4, 3, 256, 256, 0);
      push_write(0, -32768);
      push_write(1, 32767);
      push_write(4, 32767);
      push_write(16640, 1234);          // last store entry
      push_write(16641, 77);            // past the store, dropped
      push_write(32767, -1);            // past the store, dropped
      push_query(-384, 256);            // corner A of cell (0,0)
      push_query(-256, 256);            // half a cell right: midway from A to B
      push_query(-320, 192);            // upper triangle, equal offsets in x and z
      push_query(-330, 200);            // upper triangle
      push_query(-300, 180);            // upper triangle
      push_query(384, -256);            // far corner
      push_query(-8388608, -8388608);   // extrapolated beyond the clamped cell
      push_query(8388607, 8388607);
      push_query(-8388608, 8388607);
      push_query(0, 0, 1'b1);
      push_query(8388607, -8388608);

      run_phase(4, 3, 256, 256, 60);
      run_phase(2, 2, 1, 65535, 50);        // tiny cells, max gain: saturation
      run_phase(129, 2, 65535, 0, 30);      // widest grid, zero gain
      run_phase(2, 129, 0, 256, 30);        // tallest grid, zero cell size
      run_phase(0, 1, 256, 512, 30);        // counts below the range
      run_phase(255, 2, 300, 384, 30);      // column count above the range
      for (int k = 0; k < 2; k++)
         run_phase($urandom_range(2, 6), $urandom_range(2, 6),
                   $urandom_range(1, 65535), $urandom_range(0, 65535), 40);

      wait_idle();
      if (errors == 0)
         $display("[heightmap_triangle_height_query] OK");
      else
         $display("[heightmap_triangle_height_query] ERROR");
      $finish;
   end

endmodule
